[src/pedal_sensor_cadence_decoder_unit_defines.svh]
// Assertion macros shared by the cadence decoder modules.
`ifndef PEDAL_SENSOR_CADENCE_DECODER_UNIT_DEFINES_SVH
`define PEDAL_SENSOR_CADENCE_DECODER_UNIT_DEFINES_SVH

// Property that must hold whenever reset is released.
`define PSCD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next clock.
`define PSCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/pscd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscd_pkg
// Shared types, constants and helpers for the pedal cadence decoder.
// ----------------------------------------------------------------------------
package pscd_pkg;

    localparam int FILTER_SAMPLES_DEF = 15;
    localparam int TICK_RATE_HZ_DEF   = 10000;
    localparam int TIME_BITS_DEF      = 24;
    localparam int RPM_FRAC_BITS_DEF  = 4;

    localparam int CFG_W   = 24;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAGNET_COUNT    = 3'd0,
        REG_TWO_WIRE_MODE   = 3'd1,
        REG_MIN_FWD_EVENTS  = 3'd2,
        REG_MIN_TRANS_TICKS = 3'd3,
        REG_MIN_PERIOD      = 3'd4,
        REG_MAX_PERIOD      = 3'd5
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SMOOTH,
        ST_FINISH,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic tick;       // run the per-tick update on the accepted word
        logic div_start;  // load divider
        logic div_step;   // one quotient bit, or the divisor load on the first step
        logic smooth;     // fold sample into average
        logic finish;     // timeout / pedaling decision
        logic load_out;   // capture result word
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;   // a period sample was taken this tick
        logic div_last;   // final divider step
    } sts_t;

    // Gray rank of a two-bit level (a in bit 1, b in bit 0)
    function automatic logic [1:0] gray_rank(input logic [1:0] lv);
        case (lv)
            2'd0:    gray_rank = 2'd0;
            2'd1:    gray_rank = 2'd3;
            2'd2:    gray_rank = 2'd1;
            default: gray_rank = 2'd2;
        endcase
    endfunction

endpackage

[src/pscd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscd_ctrl
// Sequencer: tick update, optional serial divide and smoothing, decision, output.
// ----------------------------------------------------------------------------
`include "pedal_sensor_cadence_decoder_unit_defines.svh"
module pscd_ctrl
    import pscd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    // accept only when idle and the output register is free or draining
    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.tick   = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // first visit: the tick result decides whether to divide
                if (!sts.need_div)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.div_step = 1'b1;
                    if (sts.div_last)
                        state_next = ST_SMOOTH;
                end
            end
            ST_SMOOTH:
            begin
                cmd.smooth = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        cmd.div_start = cmd.tick;
    end

    `PSCD_ASSERT(a_no_accept_busy, !(in_valid && !in_stall && state_reg != ST_IDLE), "accept while busy")
    `PSCD_ASSERT_NEXT(a_load_valid, cmd.load_out, out_valid, "load without valid")
    `PSCD_ASSERT_NEXT(a_tick_leaves_idle, cmd.tick, state_reg == ST_DIV, "tick did not start")

endmodule

[src/pscd_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscd_dp
// Datapath: debounce, Gray decode, elapsed timers, serial divider, smoothing.
// ----------------------------------------------------------------------------
`include "pedal_sensor_cadence_decoder_unit_defines.svh"
module pscd_dp
    import pscd_pkg::*;
#(
    parameter int FILTER_SAMPLES = FILTER_SAMPLES_DEF,
    parameter int TICK_RATE_HZ   = TICK_RATE_HZ_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF,
    parameter int RPM_FRAC_BITS  = RPM_FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic        raw_a,
    input  logic        raw_b,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic        filtered_a,
    output logic        filtered_b,
    output logic        pedal_active,
    output logic [15:0] cadence_rpm,
    output logic        rpm_updated,
    output logic        backward_step
);

    localparam int CNT_W = $clog2(FILTER_SAMPLES + 1);
    localparam logic [CNT_W-1:0] FMAX = CNT_W'(FILTER_SAMPLES);
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam longint NUM = 64'(60) * 64'(TICK_RATE_HZ) * (64'(1) << RPM_FRAC_BITS);
    localparam int NUM_W = $clog2(NUM + 1);
    localparam int DEN_W = TIME_BITS + 8;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] NUM_C = NUM_W'(NUM);

    // configuration
    logic [7:0]  magnets_reg, min_fwd_reg;
    logic        two_wire_reg;
    logic [23:0] min_trans_reg, min_per_reg, max_per_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magnets_reg   <= '0;
            two_wire_reg  <= 1'b0;
            min_fwd_reg   <= '0;
            min_trans_reg <= '0;
            min_per_reg   <= '0;
            max_per_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_MAGNET_COUNT:    magnets_reg   <= cfg_data[7:0];
                REG_TWO_WIRE_MODE:   two_wire_reg  <= cfg_data[0];
                REG_MIN_FWD_EVENTS:  min_fwd_reg   <= cfg_data[7:0];
                REG_MIN_TRANS_TICKS: min_trans_reg <= cfg_data;
                REG_MIN_PERIOD:      min_per_reg   <= cfg_data;
                REG_MAX_PERIOD:      max_per_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // state
    logic [CNT_W-1:0]     cnt_a_reg, cnt_b_reg;
    logic [1:0]           filt_reg, acc_reg;
    logic                 edge_seen_reg, per_started_reg, pedal_reg;
    logic [TIME_BITS-1:0] t_edge_reg, t_per_reg;
    logic [7:0]           fwd_reg;
    logic [15:0]          avg_reg, shown_reg;
    logic                 upd_reg, back_reg;
    logic [TIME_BITS-1:0] period_reg;
    // divider
    logic [NUM_W-1:0]     quo_reg;
    logic [DEN_W:0]       rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [STEP_W-1:0]    step_reg;

    // tick combinational update
    logic [CNT_W-1:0]     ca_n, cb_n;
    logic [1:0]           lv;
    logic [TIME_BITS-1:0] te_n, tp_n;
    logic [1:0]           step;
    logic                 take, fwd_ok, is_back, dec_ok, too_early;
    logic [7:0]           fwd_n;

    always_comb
    begin
        te_n = (t_edge_reg == TMAX) ? TMAX : t_edge_reg + 1'b1;
        tp_n = (t_per_reg == TMAX) ? TMAX : t_per_reg + 1'b1;
        if (!two_wire_reg)
            ca_n = '0;
        else if (raw_a)
            ca_n = (cnt_a_reg < FMAX) ? cnt_a_reg + 1'b1 : cnt_a_reg;
        else
            ca_n = (cnt_a_reg != '0) ? cnt_a_reg - 1'b1 : cnt_a_reg;
        if (raw_b)
            cb_n = (cnt_b_reg < FMAX) ? cnt_b_reg + 1'b1 : cnt_b_reg;
        else
            cb_n = (cnt_b_reg != '0) ? cnt_b_reg - 1'b1 : cnt_b_reg;
        lv = filt_reg;
        if (ca_n >= FMAX) lv[1] = 1'b1;
        else if (ca_n == '0) lv[1] = 1'b0;
        if (cb_n >= FMAX) lv[0] = 1'b1;
        else if (cb_n == '0) lv[0] = 1'b0;
        step = gray_rank(lv) - gray_rank(acc_reg);
        too_early = edge_seen_reg && ({8'd0, te_n} < {8'd0, min_trans_reg});
        dec_ok = (lv != filt_reg) && (magnets_reg != '0) && (min_trans_reg != '0)
                 && (lv != acc_reg) && !too_early
                 && !(two_wire_reg && step == 2'd2);
        is_back = dec_ok && two_wire_reg && step == 2'd3;
        fwd_ok  = dec_ok && !is_back;
        fwd_n = fwd_reg;
        if (is_back) fwd_n = '0;
        else if (fwd_ok && fwd_reg < min_fwd_reg) fwd_n = fwd_reg + 1'b1;
        take = fwd_ok && lv == 2'd0 && per_started_reg
               && ({8'd0, tp_n} >= {8'd0, min_per_reg}) && tp_n != '0;
    end

    logic [DEN_W:0] trial;
    assign trial = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]} - {1'b0, den_reg};

    // smoothing: (4*avg + s)/5 via reciprocal multiply
    logic [15:0] sample;
    logic [18:0] sum5;
    logic [15:0] avg5;
    logic [37:0] prod;
    always_comb
    begin
        sample = (quo_reg > NUM_W'(16'hFFFF)) ? 16'hFFFF : quo_reg[15:0];
        sum5   = {1'b0, avg_reg, 2'b00} + 19'(sample);
        prod   = 38'(sum5) * 38'd838861;      // ceil(2^22/5), exact for sums below 2^22
        avg5   = prod[37:22];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0; cnt_b_reg <= '0; filt_reg <= '0; acc_reg <= '0;
            edge_seen_reg <= 1'b0; per_started_reg <= 1'b0; pedal_reg <= 1'b0;
            t_edge_reg <= '0; t_per_reg <= '0; fwd_reg <= '0;
            avg_reg <= '0; shown_reg <= '0; upd_reg <= 1'b0; back_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (cmd.tick)
            begin
                cnt_a_reg <= ca_n;
                cnt_b_reg <= cb_n;
                filt_reg  <= lv;
                fwd_reg   <= fwd_n;
                back_reg  <= is_back;
                upd_reg   <= take;
                t_edge_reg <= dec_ok ? '0 : te_n;
                if (dec_ok)
                begin
                    acc_reg       <= lv;
                    edge_seen_reg <= 1'b1;
                end
                if (fwd_ok && lv == 2'd0 && !per_started_reg)
                begin
                    per_started_reg <= 1'b1;
                    t_per_reg       <= '0;
                end
                else if (take)
                    t_per_reg <= '0;
                else
                    t_per_reg <= tp_n;
            end
            if (cmd.div_start)
                step_reg <= STEP_W'(NUM_W);
            else if (cmd.div_step)
                step_reg <= step_reg - 1'b1;
            if (cmd.smooth)
            begin
                avg_reg   <= (avg_reg == '0) ? sample : avg5;
                shown_reg <= (avg_reg == '0) ? sample : avg5;
            end
            if (cmd.finish)
            begin
                if (!per_started_reg || {8'd0, t_per_reg} > {8'd0, max_per_reg})
                begin
                    pedal_reg <= 1'b0; shown_reg <= '0; avg_reg <= '0; fwd_reg <= '0;
                end
                else if (fwd_reg < min_fwd_reg)
                begin
                    pedal_reg <= 1'b0; shown_reg <= '0;
                end
                else
                    pedal_reg <= 1'b1;
            end
        end
    end

    // divider payload, restoring: divisor load, then one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (cmd.tick)
            period_reg <= tp_n;
        if (cmd.div_start)
        begin
            quo_reg <= NUM_C;
            rem_reg <= '0;
            den_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (step_reg == STEP_W'(NUM_W))
                den_reg <= DEN_W'(magnets_reg) * DEN_W'(period_reg);
            if (step_reg != STEP_W'(NUM_W) && !trial[DEN_W])
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
            end
            else if (step_reg != STEP_W'(NUM_W))
            begin
                rem_reg <= {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
                quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    assign sts.need_div = upd_reg;
    assign sts.div_last = (step_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            filtered_a    <= filt_reg[1];
            filtered_b    <= filt_reg[0];
            pedal_active  <= pedal_reg;
            cadence_rpm   <= shown_reg;
            rpm_updated   <= upd_reg;
            backward_step <= back_reg;
        end
    end

    `PSCD_ASSERT(a_back_clears, !(cmd.tick && is_back && take), "backward with period")
    `PSCD_ASSERT_NEXT(a_one_wire_a, cmd.tick && !two_wire_reg, cnt_a_reg == '0, "wire a not held")
    `PSCD_ASSERT(a_pedal_after_start, !(pedal_reg && !per_started_reg), "pedaling before start")

endmodule

[src/pedal_sensor_cadence_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pedal_sensor_cadence_decoder_unit
// Pedal-sensor debounce, quadrature decode and period tachometer.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid/in_stall) carries one sample tick: raw_a, raw_b.
//   Output channel (out_valid/out_stall) returns exactly one result word per
//   tick: filtered levels, pedaling flag, rpm (Q12.4), update/backward flags.
//   Configuration is a plain write port (cfg_we, cfg_idx, cfg_data); write
//   only while no tick is in flight.
// Sequence:
//   A tick with no period sample: tick update, then decision, then load of
//   the result word; the next tick is taken only once the controller is idle.
//   A tick that takes a period sample runs the restoring divider: it loads
//   the divisor, then yields one quotient bit a cycle, then smoothing,
//   decision and load follow. One tick is in flight at a time.
// Reset:
//   All configuration and decoder state clear to zero; output invalid.
// Stall:
//   The result word holds in the output register while out_stall is high;
//   the next tick is not taken until that word leaves.
// ----------------------------------------------------------------------------
module pedal_sensor_cadence_decoder_unit
    import pscd_pkg::*;
#(
    parameter int FILTER_SAMPLES = FILTER_SAMPLES_DEF,
    parameter int TICK_RATE_HZ   = TICK_RATE_HZ_DEF,
    parameter int TIME_BITS      = TIME_BITS_DEF,
    parameter int RPM_FRAC_BITS  = RPM_FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 raw_a,
    input  logic                 raw_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 filtered_a,
    output logic                 filtered_b,
    output logic                 pedal_active,
    output logic [15:0]          cadence_rpm,
    output logic                 rpm_updated,
    output logic                 backward_step
);

    cmd_t cmd;
    sts_t sts;

    pscd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    pscd_dp #(
        .FILTER_SAMPLES (FILTER_SAMPLES),
        .TICK_RATE_HZ   (TICK_RATE_HZ),
        .TIME_BITS      (TIME_BITS),
        .RPM_FRAC_BITS  (RPM_FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_idx       (cfg_idx),
        .cfg_data      (cfg_data),
        .raw_a         (raw_a),
        .raw_b         (raw_b),
        .cmd           (cmd),
        .sts           (sts),
        .filtered_a    (filtered_a),
        .filtered_b    (filtered_b),
        .pedal_active  (pedal_active),
        .cadence_rpm   (cadence_rpm),
        .rpm_updated   (rpm_updated),
        .backward_step (backward_step)
    );

endmodule

[dv/tb_pedal_sensor_cadence_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pedal_sensor_cadence_decoder_unit
// Self-checking bench for the pedal cadence decoder: a directed table of
// sample ticks, then phased random pedaling waveforms under several register
// settings, each result word checked against an in-bench cadence model.
// ----------------------------------------------------------------------------
module tb_pedal_sensor_cadence_decoder_unit;
    import pscd_pkg::*;

    localparam int FILT = FILTER_SAMPLES_DEF;
    localparam logic [23:0] TIME_TOP = 24'hFFFFFF;
    localparam longint RPM_NUM = 64'd60 * TICK_RATE_HZ_DEF * (64'd1 << RPM_FRAC_BITS_DEF);

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic raw_a = 1'b0;
    logic raw_b = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic filtered_a, filtered_b, pedal_active, rpm_updated, backward_step;
    logic [15:0] cadence_rpm;

    pedal_sensor_cadence_decoder_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .raw_a(raw_a), .raw_b(raw_b),
        .out_valid(out_valid), .out_stall(out_stall),
        .filtered_a(filtered_a), .filtered_b(filtered_b), .pedal_active(pedal_active),
        .cadence_rpm(cadence_rpm), .rpm_updated(rpm_updated), .backward_step(backward_step)
    );

    always #6 clk = ~clk;

    // one result word
    typedef struct packed {
        logic        fa;
        logic        fb;
        logic        ped;
        logic [15:0] rpm;
        logic        upd;
        logic        bwd;
    } cadence_word_t;

    // model copy of the registers
    logic [7:0]  m_magnets;
    logic        m_two_wire;
    logic [7:0]  m_min_fwd;
    logic [23:0] m_min_trans, m_min_period, m_max_period;

    // model copy of the decoder state
    logic [3:0]  dc_a, dc_b;
    logic [1:0]  filt_lv, acc_lv;
    logic        edge_seen, period_started, pedaling;
    logic [23:0] since_edge, since_period;
    logic [7:0]  fwd_count;
    logic [15:0] rpm_avg, rpm_shown;

    cadence_word_t expected_words[$];
    int errors = 0;
    int words_checked = 0;
    int words_sent = 0;
    int updates_seen = 0;
    int backwards_seen = 0;
    bit rx_idle_on = 1'b1;
    bit tx_idle_on = 1'b1;
    bit hold_rx = 1'b0;

    function automatic logic [1:0] rank_of(input logic [1:0] lv);
        case (lv)
            2'd0: return 2'd0;
            2'd1: return 2'd3;
            2'd2: return 2'd1;
            default: return 2'd2;
        endcase
    endfunction

    function automatic logic [3:0] filter_step(input logic [3:0] c, input logic hi);
        if (hi) return (c < FILT) ? c + 4'd1 : c;
        return (c > 0) ? c - 4'd1 : c;
    endfunction

    task automatic reset_cadence_state();
        m_magnets = 0; m_two_wire = 0; m_min_fwd = 0;
        m_min_trans = 0; m_min_period = 0; m_max_period = 0;
        dc_a = 0; dc_b = 0; filt_lv = 0; acc_lv = 0;
        edge_seen = 0; period_started = 0; pedaling = 0;
        since_edge = 0; since_period = 0; fwd_count = 0;
        rpm_avg = 0; rpm_shown = 0;
    endtask

    task automatic sample_period(inout logic upd);
        longint per, smp;
        if (!period_started)
        begin
            period_started = 1;
            since_period = 0;
            return;
        end
        per = since_period;
        if (per < m_min_period || per == 0) return;
        since_period = 0;
        smp = RPM_NUM / (longint'(m_magnets) * per);
        if (smp > 65535) smp = 65535;
        if (rpm_avg == 0) rpm_avg = smp[15:0];
        else rpm_avg = 16'((4 * longint'(rpm_avg) + smp) / 5);
        rpm_shown = rpm_avg;
        upd = 1;
    endtask

    task automatic decode_levels(input logic [1:0] lv, inout logic upd, inout logic bwd);
        logic [1:0] st;
        if (m_magnets == 0 || m_min_trans == 0) return;
        if (lv == acc_lv) return;
        if (edge_seen && since_edge < m_min_trans) return;
        if (m_two_wire)
        begin
            st = rank_of(lv) - rank_of(acc_lv);
            if (st == 2'd2) return;
            acc_lv = lv; edge_seen = 1; since_edge = 0;
            if (st == 2'd3)
            begin
                fwd_count = 0;
                bwd = 1;
                return;
            end
        end
        else
        begin
            acc_lv = lv; edge_seen = 1; since_edge = 0;
        end
        if (fwd_count < m_min_fwd) fwd_count++;
        if (lv == 2'd0) sample_period(upd);
    endtask

    // advance the model by one sample tick and return its result word
    task automatic predict_cadence(input logic ra, input logic rb, output cadence_word_t w);
        logic upd, bwd;
        logic [1:0] lv;
        upd = 0; bwd = 0;
        if (since_edge != TIME_TOP) since_edge++;
        if (since_period != TIME_TOP) since_period++;
        dc_a = m_two_wire ? filter_step(dc_a, ra) : 4'd0;
        dc_b = filter_step(dc_b, rb);
        lv = filt_lv;
        if (dc_a >= FILT) lv[1] = 1; else if (dc_a == 0) lv[1] = 0;
        if (dc_b >= FILT) lv[0] = 1; else if (dc_b == 0) lv[0] = 0;
        if (lv != filt_lv)
        begin
            filt_lv = lv;
            decode_levels(lv, upd, bwd);
        end
        if (!period_started || since_period > m_max_period)
        begin
            pedaling = 0; rpm_shown = 0; rpm_avg = 0; fwd_count = 0;
        end
        else if (fwd_count < m_min_fwd)
        begin
            pedaling = 0; rpm_shown = 0;
        end
        else
            pedaling = 1;
        w = '{fa: filt_lv[1], fb: filt_lv[0], ped: pedaling, rpm: rpm_shown,
              upd: upd, bwd: bwd};
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        $display("MISMATCH word %0d %s: got %0d expected %0d", words_checked, what, got, want);
    endtask

    // -------- result side: random stall bursts, long hold on request --------
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_rx)
                out_stall <= 1'b1;
            else if (rx_idle_on && $urandom_range(0, 9) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // checker: sampled at the edge, compares with the oldest expectation
    always @(posedge clk)
    begin
        cadence_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with nothing expected", 1, 0);
            else
            begin
                e = expected_words.pop_front();
                if (filtered_a !== e.fa) report_mismatch("filtered_a", filtered_a, e.fa);
                if (filtered_b !== e.fb) report_mismatch("filtered_b", filtered_b, e.fb);
                if (pedal_active !== e.ped) report_mismatch("pedal_active", pedal_active, e.ped);
                if (cadence_rpm !== e.rpm) report_mismatch("cadence_rpm", cadence_rpm, e.rpm);
                if (rpm_updated !== e.upd) report_mismatch("rpm_updated", rpm_updated, e.upd);
                if (backward_step !== e.bwd)
                    report_mismatch("backward_step", backward_step, e.bwd);
                updates_seen += e.upd;
                backwards_seen += e.bwd;
                words_checked++;
            end
        end
    end

    // offer one tick word; prediction happens when it is taken
    task automatic send_tick(input logic ra, input logic rb);
        cadence_word_t w;
        int n;
        if (tx_idle_on && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_a <= ra;
        raw_b <= rb;
        do @(posedge clk); while (in_stall);
        predict_cadence(ra, rb, w);
        expected_words.push_back(w);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // write enable stays up across back-to-back writes of one setting
    task automatic write_reg(input reg_idx_t idx, input logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_MAGNET_COUNT:    m_magnets = val[7:0];
            REG_TWO_WIRE_MODE:   m_two_wire = val[0];
            REG_MIN_FWD_EVENTS:  m_min_fwd = val[7:0];
            REG_MIN_TRANS_TICKS: m_min_trans = val;
            REG_MIN_PERIOD:      m_min_period = val;
            default:             m_max_period = val;
        endcase
    endtask

    task automatic set_config(input logic [7:0] mag, input logic tw, input logic [7:0] mf,
                              input logic [23:0] mt, input logic [23:0] mnp,
                              input logic [23:0] mxp);
        write_reg(REG_MAGNET_COUNT, 24'(mag));
        write_reg(REG_TWO_WIRE_MODE, 24'(tw));
        write_reg(REG_MIN_FWD_EVENTS, 24'(mf));
        write_reg(REG_MIN_TRANS_TICKS, mt);
        write_reg(REG_MIN_PERIOD, mnp);
        write_reg(REG_MAX_PERIOD, mxp);
        cfg_we <= 1'b0;
    endtask

    // hold both wires at a level long enough for the filter to settle
    task automatic hold_levels(input logic [1:0] lv, input int len);
        repeat (len)
            send_tick($urandom_range(0, 5) == 0 ? ~lv[1] : lv[1],
                      $urandom_range(0, 5) == 0 ? ~lv[0] : lv[0]);
    endtask

    // directed table: raw a, raw b, and a typed-in expectation where obvious
    typedef struct {
        logic ra;
        logic rb;
        logic known;
        cadence_word_t want;
    } tick_row_t;

    tick_row_t dir_rows[20];

    initial
    begin
        cadence_word_t w;
        logic [1:0] lv;
        reset_cadence_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset decoding is off: filtered outputs only, never pedaling
        for (int i = 0; i < 20; i++)
        begin
            dir_rows[i].ra = 1'b1;
            dir_rows[i].rb = (i < 18);
            dir_rows[i].known = (i < 14);
            dir_rows[i].want = '0;
        end
        dir_rows[14].known = 1'b1;
        dir_rows[14].want = '{fa: 0, fb: 1, ped: 0, rpm: 0, upd: 0, bwd: 0};
        foreach (dir_rows[i])
        begin
            send_tick(dir_rows[i].ra, dir_rows[i].rb);
            w = expected_words[$];
            if (dir_rows[i].known && w != dir_rows[i].want)
                report_mismatch($sformatf("directed row %0d", i), w, dir_rows[i].want);
        end
        drain();

        // single wire, largest magnet count, extremes of the timing registers
        set_config(8'd255, 1'b0, 8'd0, 24'd1, 24'd0, 24'hFFFFFF);
        for (int k = 0; k < 6; k++) hold_levels(k[0] ? 2'b01 : 2'b00, 17);
        drain();

        // pressure: hold the result side while the sender keeps offering
        set_config(8'd1, 1'b1, 8'd2, 24'd3, 24'd4, 24'd2000);
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge clk);
                hold_rx = 1'b0;
            end
        join_none
        lv = 2'b00;
        for (int k = 0; k < 10; k++)
        begin
            lv = rank_of(rank_of(lv) + 2'd1) == 2'd0 ? 2'd0 : lv;
            hold_levels(lv, 16);
            lv = (lv == 2'b00) ? 2'b10 : (lv == 2'b10) ? 2'b11 : (lv == 2'b11) ? 2'b01 : 2'b00;
        end
        drain();

        // random phases: forward-mostly quadrature with backward, invalid
        // jumps and noise, under a spread of settings
        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 5)
            begin
                rx_idle_on = 0;
                tx_idle_on = 0;
                set_config(8'd0, 1'b1, 8'd255, 24'hFFFFFF, 24'hFFFFFF, 24'd0);
            end
            else
                set_config(8'($urandom_range(1, 8)), ph != 2, 8'($urandom_range(0, 4)),
                           24'($urandom_range(1, 20)), 24'($urandom_range(0, 60)),
                           24'($urandom_range(30, 900)));
            lv = filt_lv;
            while (words_sent < 280 + 45 * (ph + 1))
            begin
                case ($urandom_range(0, 9))
                    0: lv = ~lv;                      // invalid jump
                    1: lv = (lv == 2'b00) ? 2'b01 : (lv == 2'b01) ? 2'b11 :
                            (lv == 2'b11) ? 2'b10 : 2'b00; // backward
                    2: lv = 2'($urandom);             // noise
                    default: lv = (lv == 2'b00) ? 2'b10 : (lv == 2'b10) ? 2'b11 :
                                  (lv == 2'b11) ? 2'b01 : 2'b00;
                endcase
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 6)) send_tick(1'($urandom), 1'($urandom));
                else
                    hold_levels(lv, $urandom_range(15, 24));
            end
            // sender waits out every expected word before the next setting
            drain();
        end

        $display("Covered %0d ticks, %0d rpm samples and %0d backward steps", words_sent,
                 updates_seen, backwards_seen);
        $display("across single and two-wire modes, register extremes and stall pressure.");
        if (errors == 0)
            $display("pedal_sensor_cadence_decoder_unit test passed");
        else
            $display("pedal_sensor_cadence_decoder_unit test failed");
        $finish;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #20ms;
        $display("pedal_sensor_cadence_decoder_unit test failed");
        $finish;
    end

endmodule
